// ===== hw/rtl/assert_macros.svh =====
// Assertion macros shared by the relative-angle check RTL
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked check, switched off while reset is held
`define TRAC_ASSERT(label, clk, rst_n, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error(msg);

// Clocked check that also holds through reset
`define TRAC_ASSERT_ALWAYS(label, clk, prop, msg) \
    label: assert property (@(posedge clk) prop) else $error(msg);

`endif

// ===== hw/rtl/trac_pkg.sv =====
// Shared widths, register codes and types for the relative-angle check
`timescale 1ns / 1ps

package trac_pkg;

    // Field widths
    localparam int POS_W      = 28;
    localparam int DIFF_W     = POS_W + 1;
    localparam int COS_W      = 16;
    localparam int SIN_W      = 15;
    localparam int DIST_W     = 16;
    localparam int IDX_OUT_W  = 12;

    // Configuration port
    localparam int CFG_ADDR_W = 2;
    localparam int CFG_DATA_W = 16;
    localparam logic [CFG_ADDR_W-1:0] CFG_COS_LIMIT = 2'd0;
    localparam logic [CFG_ADDR_W-1:0] CFG_SIN_LIMIT = 2'd1;
    localparam logic [CFG_ADDR_W-1:0] CFG_MIN_DIST  = 2'd2;

    // Register reset values
    localparam logic signed [COS_W-1:0] COS_LIMIT_RST = 16'sd23170;
    localparam logic [SIN_W-1:0]        SIN_LIMIT_RST = 15'd23170;
    localparam logic [DIST_W-1:0]       MIN_DIST_RST  = 16'd51;

    // Shared multiplier and accumulator
    localparam int MUL_W  = 30;
    localparam int PROD_W = 2 * MUL_W;
    localparam int ACC_W  = 76;
    localparam int MD_W   = 2 * DIST_W;
    localparam int DOT_W  = 2 * DIFF_W;
    localparam int CRS_W  = DOT_W - 1;
    localparam int SPLIT  = 29;

    localparam int DEF_MAX_POINTS = 4096;

    // Status from the angle unit back to the track control
    typedef struct packed {
        logic done;
        logic fail;
    } t_angle_sts;

endpackage

// ===== hw/rtl/trac_mul.sv =====
// Shared signed multiplier with registered product
`timescale 1ns / 1ps

module trac_mul (
    input  logic                              i_clk,
    input  logic signed [trac_pkg::MUL_W-1:0]  i_a,
    input  logic signed [trac_pkg::MUL_W-1:0]  i_b,
    output logic signed [trac_pkg::PROD_W-1:0] o_prod
);
    import trac_pkg::*;

    logic signed [PROD_W-1:0] r_prod;

    // One product per cycle, registered before any add
    always_ff @(posedge i_clk) begin
        r_prod <= i_a * i_b;
    end

    assign o_prod = r_prod;

endmodule

// ===== hw/rtl/trac_angle.sv =====
// Window evaluation: distance tests and exact angle test on one multiplier
`timescale 1ns / 1ps
`include "assert_macros.svh"

module trac_angle (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               i_start,
    input  logic signed [trac_pkg::POS_W-1:0]  i_x1,
    input  logic signed [trac_pkg::POS_W-1:0]  i_y1,
    input  logic signed [trac_pkg::POS_W-1:0]  i_x2,
    input  logic signed [trac_pkg::POS_W-1:0]  i_y2,
    input  logic signed [trac_pkg::POS_W-1:0]  i_x3,
    input  logic signed [trac_pkg::POS_W-1:0]  i_y3,
    input  logic signed [trac_pkg::COS_W-1:0]  i_cos_limit,
    input  logic        [trac_pkg::SIN_W-1:0]  i_sin_limit,
    input  logic        [trac_pkg::DIST_W-1:0] i_min_dist,
    output trac_pkg::t_angle_sts               o_sts
);
    import trac_pkg::*;

    // Micro-op sequence, one multiply each
    localparam logic [3:0] OP_MD      = 4'd0;   // min_dist^2
    localparam logic [3:0] OP_AXX     = 4'd1;
    localparam logic [3:0] OP_AYY     = 4'd2;   // |p2-p1|^2 done
    localparam logic [3:0] OP_BXX     = 4'd3;
    localparam logic [3:0] OP_BYY     = 4'd4;   // |p3-p1|^2 done
    localparam logic [3:0] OP_AXBX    = 4'd5;
    localparam logic [3:0] OP_AYBY    = 4'd6;   // dot done
    localparam logic [3:0] OP_AXBY    = 4'd7;
    localparam logic [3:0] OP_AYBX    = 4'd8;   // cross done
    localparam logic [3:0] OP_CHI_COS = 4'd9;
    localparam logic [3:0] OP_DHI_SIN = 4'd10;
    localparam logic [3:0] OP_CLO_COS = 4'd11;
    localparam logic [3:0] OP_DLO_SIN = 4'd12;  // sign of difference

    logic                     r_busy, n_busy;
    logic                     r_ph, n_ph;
    logic [3:0]               r_op, n_op;
    logic signed [DIFF_W-1:0] r_ax, r_ay, r_bx, r_by;
    logic signed [DIFF_W-1:0] n_ax, n_ay, n_bx, n_by;
    logic [MD_W-1:0]          r_md, n_md;
    logic signed [ACC_W-1:0]  r_acc, n_acc;
    logic signed [DOT_W-1:0]  r_dot, n_dot;
    logic [CRS_W-1:0]         r_crs, n_crs;
    logic                     r_done, n_done;
    logic                     r_fail, n_fail;

    logic signed [MUL_W-1:0]  w_mul_a, w_mul_b;
    logic signed [PROD_W-1:0] w_prod;
    logic signed [ACC_W-1:0]  w_prod_ext;
    logic signed [ACC_W-1:0]  w_md_ext;

    // Operand select for the shared multiplier
    always_comb begin
        unique case (r_op)
            OP_MD: begin
                w_mul_a = MUL_W'(i_min_dist);
                w_mul_b = MUL_W'(i_min_dist);
            end
            OP_AXX: begin
                w_mul_a = MUL_W'(r_ax);
                w_mul_b = MUL_W'(r_ax);
            end
            OP_AYY: begin
                w_mul_a = MUL_W'(r_ay);
                w_mul_b = MUL_W'(r_ay);
            end
            OP_BXX: begin
                w_mul_a = MUL_W'(r_bx);
                w_mul_b = MUL_W'(r_bx);
            end
            OP_BYY: begin
                w_mul_a = MUL_W'(r_by);
                w_mul_b = MUL_W'(r_by);
            end
            OP_AXBX: begin
                w_mul_a = MUL_W'(r_ax);
                w_mul_b = MUL_W'(r_bx);
            end
            OP_AYBY: begin
                w_mul_a = MUL_W'(r_ay);
                w_mul_b = MUL_W'(r_by);
            end
            OP_AXBY: begin
                w_mul_a = MUL_W'(r_ax);
                w_mul_b = MUL_W'(r_by);
            end
            OP_AYBX: begin
                w_mul_a = MUL_W'(r_ay);
                w_mul_b = MUL_W'(r_bx);
            end
            OP_CHI_COS: begin
                w_mul_a = MUL_W'(r_crs[CRS_W-1:SPLIT]);
                w_mul_b = MUL_W'(i_cos_limit);
            end
            OP_DHI_SIN: begin
                w_mul_a = MUL_W'($signed(r_dot[DOT_W-1:SPLIT]));
                w_mul_b = MUL_W'(i_sin_limit);
            end
            OP_CLO_COS: begin
                w_mul_a = MUL_W'(r_crs[SPLIT-1:0]);
                w_mul_b = MUL_W'(i_cos_limit);
            end
            OP_DLO_SIN: begin
                w_mul_a = MUL_W'(r_dot[SPLIT-1:0]);
                w_mul_b = MUL_W'(i_sin_limit);
            end
            default: begin
                w_mul_a = '0;
                w_mul_b = '0;
            end
        endcase
    end

    trac_mul u_mul (
        .i_clk  (i_clk),
        .i_a    (w_mul_a),
        .i_b    (w_mul_b),
        .o_prod (w_prod)
    );

    assign w_prod_ext = ACC_W'(w_prod);
    assign w_md_ext   = ACC_W'(r_md);

    // Sequencer: phase 0 multiplies, phase 1 accumulates and tests
    always_comb begin
        logic                    v_fin;
        logic                    v_fail;
        logic signed [ACC_W-1:0] v_abs;

        v_fin  = 1'b0;
        v_fail = 1'b0;
        v_abs  = '0;
        n_busy = r_busy;
        n_ph   = r_ph;
        n_op   = r_op;
        n_ax   = r_ax;
        n_ay   = r_ay;
        n_bx   = r_bx;
        n_by   = r_by;
        n_md   = r_md;
        n_acc  = r_acc;
        n_dot  = r_dot;
        n_crs  = r_crs;
        n_done = 1'b0;
        n_fail = r_fail;

        if (i_start) begin
            n_busy = 1'b1;
            n_ph   = 1'b0;
            n_op   = OP_MD;
            n_fail = 1'b0;
            n_ax   = DIFF_W'(i_x2) - DIFF_W'(i_x1);
            n_ay   = DIFF_W'(i_y2) - DIFF_W'(i_y1);
            n_bx   = DIFF_W'(i_x3) - DIFF_W'(i_x1);
            n_by   = DIFF_W'(i_y3) - DIFF_W'(i_y1);
        end else if (r_busy) begin
            if (!r_ph) begin
                n_ph = 1'b1;
            end else begin
                n_ph = 1'b0;
                n_op = r_op + 4'd1;
                unique case (r_op)
                    OP_MD: begin
                        n_md = w_prod[MD_W-1:0];
                    end
                    OP_AXX, OP_BXX, OP_AXBX, OP_AXBY, OP_CHI_COS: begin
                        n_acc = w_prod_ext;
                    end
                    OP_AYY, OP_BYY: begin
                        // short or zero leg: window skipped
                        n_acc = r_acc + w_prod_ext;
                        if (n_acc == '0 || n_acc < w_md_ext) begin
                            v_fin = 1'b1;
                        end
                    end
                    OP_AYBY: begin
                        n_acc = r_acc + w_prod_ext;
                        n_dot = n_acc[DOT_W-1:0];
                    end
                    OP_AYBX: begin
                        n_acc = r_acc - w_prod_ext;
                        v_abs = n_acc[ACC_W-1] ? -n_acc : n_acc;
                        n_crs = v_abs[CRS_W-1:0];
                        // straight back: angle is pi
                        if (n_acc == '0 && r_dot[DOT_W-1]) begin
                            v_fin  = 1'b1;
                            v_fail = !(i_sin_limit == '0 && i_cos_limit[COS_W-1]);
                        end
                    end
                    OP_DHI_SIN: begin
                        n_acc = r_acc - w_prod_ext;
                    end
                    OP_CLO_COS: begin
                        n_acc = (r_acc <<< SPLIT) + w_prod_ext;
                    end
                    OP_DLO_SIN: begin
                        // c*cos - d*sin > 0 means angle over threshold
                        n_acc  = r_acc - w_prod_ext;
                        v_fin  = 1'b1;
                        v_fail = (n_acc > 0);
                    end
                    default: begin
                        v_fin = 1'b1;
                    end
                endcase
                if (v_fin) begin
                    n_busy = 1'b0;
                    n_done = 1'b1;
                    n_fail = v_fail;
                end
            end
        end
    end

    // Control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_ph   <= 1'b0;
            r_op   <= OP_MD;
            r_done <= 1'b0;
            r_fail <= 1'b0;
        end else begin
            r_busy <= n_busy;
            r_ph   <= n_ph;
            r_op   <= n_op;
            r_done <= n_done;
            r_fail <= n_fail;
        end
    end

    // Datapath registers
    always_ff @(posedge i_clk) begin
        r_ax  <= n_ax;
        r_ay  <= n_ay;
        r_bx  <= n_bx;
        r_by  <= n_by;
        r_md  <= n_md;
        r_acc <= n_acc;
        r_dot <= n_dot;
        r_crs <= n_crs;
    end

    assign o_sts = '{done: r_done, fail: r_fail};

    `TRAC_ASSERT(a_start_idle, i_clk, i_rst_n, i_start |-> !r_busy, "start while busy")
    `TRAC_ASSERT(a_done_pulse, i_clk, i_rst_n, r_done |=> !r_done, "done held two cycles")
    `TRAC_ASSERT_ALWAYS(a_done_free, i_clk, r_done |-> !r_busy, "done while still busy")

endmodule

// ===== hw/rtl/trajectory_relative_angle_check_unit.sv =====
// Top level: point window tracking, config registers and result register
//
//  channel   direction  handshake            word
//  input     in         i_valid / o_ready    i_pos_x, i_pos_y, i_reversing, i_last
//  result    out        o_valid / i_ready    o_pass, o_fail_index
//  config    in         i_cfg_wr_en          i_cfg_addr, i_cfg_wr_data
//
// A point that opens no window passes through accept and commit.
// A checked window goes through accept, start, 13 multiplies on one 30x30 multiplier
// (operand phase, accumulate phase each), done and commit; a short leg ends early.
// Reset is synchronous, active low; it restores the limits and clears the track.
// The result register frees the input side: only a final point waits for it to empty.
`timescale 1ns / 1ps
`include "assert_macros.svh"

module trajectory_relative_angle_check_unit #(
    parameter int MAX_POINTS = trac_pkg::DEF_MAX_POINTS
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_cfg_wr_en,
    input  logic [trac_pkg::CFG_ADDR_W-1:0]     i_cfg_addr,
    input  logic [trac_pkg::CFG_DATA_W-1:0]     i_cfg_wr_data,
    input  logic                                i_valid,
    output logic                                o_ready,
    input  logic signed [trac_pkg::POS_W-1:0]   i_pos_x,
    input  logic signed [trac_pkg::POS_W-1:0]   i_pos_y,
    input  logic                                i_reversing,
    input  logic                                i_last,
    output logic                                o_valid,
    input  logic                                i_ready,
    output logic                                o_pass,
    output logic [trac_pkg::IDX_OUT_W-1:0]      o_fail_index
);
    import trac_pkg::*;

    localparam int IDX_W = $clog2(MAX_POINTS);

    localparam logic [1:0] ST_IDLE   = 2'd0;
    localparam logic [1:0] ST_CALC   = 2'd1;
    localparam logic [1:0] ST_COMMIT = 2'd2;

    logic [1:0]              r_state, n_state;
    logic signed [COS_W-1:0] r_cos_limit;
    logic [SIN_W-1:0]        r_sin_limit;
    logic [DIST_W-1:0]       r_min_dist;

    logic signed [POS_W-1:0] r_in_x, r_in_y;
    logic                    r_in_rev, r_in_last;
    logic signed [POS_W-1:0] r_prev_x [2];
    logic signed [POS_W-1:0] r_prev_y [2];
    logic                    r_prev_rev [2];
    logic [IDX_W-1:0]        r_idx;
    logic                    r_failed;
    logic [IDX_W-1:0]        r_failed_at;
    logic                    r_start;

    logic                    r_out_valid;
    logic                    r_pass;
    logic [IDX_OUT_W-1:0]    r_fail_index;

    logic                    w_accept;
    logic                    w_eval;
    logic                    w_emit;
    logic                    w_shift;
    t_angle_sts              w_sts;

    assign o_ready  = (r_state == ST_IDLE);
    assign w_accept = i_valid && o_ready;

    // Window is checked only with two earlier points, no failure yet, all forward
    assign w_eval = (r_idx >= IDX_W'(2)) && !r_failed && !i_reversing
                    && !r_prev_rev[0] && !r_prev_rev[1];

    assign w_emit  = (r_state == ST_COMMIT) && r_in_last && (!r_out_valid || i_ready);
    assign w_shift = (r_state == ST_COMMIT) && !r_in_last;

    // Sequencer
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ST_IDLE: begin
                if (w_accept) begin
                    n_state = w_eval ? ST_CALC : ST_COMMIT;
                end
            end
            ST_CALC: begin
                if (w_sts.done) begin
                    n_state = ST_COMMIT;
                end
            end
            ST_COMMIT: begin
                if (w_emit || w_shift) begin
                    n_state = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    // Configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cos_limit <= COS_LIMIT_RST;
            r_sin_limit <= SIN_LIMIT_RST;
            r_min_dist  <= MIN_DIST_RST;
        end else if (i_cfg_wr_en) begin
            unique case (i_cfg_addr)
                CFG_COS_LIMIT: r_cos_limit <= $signed(i_cfg_wr_data[COS_W-1:0]);
                CFG_SIN_LIMIT: r_sin_limit <= i_cfg_wr_data[SIN_W-1:0];
                CFG_MIN_DIST:  r_min_dist  <= i_cfg_wr_data[DIST_W-1:0];
                default: ;
            endcase
        end
    end

    // Track state and control
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state       <= ST_IDLE;
            r_start       <= 1'b0;
            r_idx         <= '0;
            r_failed      <= 1'b0;
            r_failed_at   <= '0;
            r_prev_rev[0] <= 1'b0;
            r_prev_rev[1] <= 1'b0;
            r_out_valid   <= 1'b0;
        end else begin
            r_state <= n_state;
            r_start <= w_accept && w_eval;

            // record first failing window
            if (r_state == ST_CALC && w_sts.done && w_sts.fail) begin
                r_failed    <= 1'b1;
                r_failed_at <= r_idx - IDX_W'(2);
            end

            if (w_emit) begin
                r_idx         <= '0;
                r_failed      <= 1'b0;
                r_failed_at   <= '0;
                r_prev_rev[0] <= 1'b0;
                r_prev_rev[1] <= 1'b0;
            end else if (w_shift) begin
                r_prev_rev[1] <= r_prev_rev[0];
                r_prev_rev[0] <= r_in_rev;
                if (r_idx != IDX_W'(MAX_POINTS - 1)) begin
                    r_idx <= r_idx + IDX_W'(1);
                end
            end

            // result register
            if (w_emit) begin
                r_out_valid <= 1'b1;
            end else if (i_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // Point payload
    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_in_x    <= i_pos_x;
            r_in_y    <= i_pos_y;
            r_in_rev  <= i_reversing;
            r_in_last <= i_last;
        end
        if (w_shift) begin
            r_prev_x[1] <= r_prev_x[0];
            r_prev_y[1] <= r_prev_y[0];
            r_prev_x[0] <= r_in_x;
            r_prev_y[0] <= r_in_y;
        end
        if (w_emit) begin
            r_pass       <= !r_failed;
            r_fail_index <= IDX_OUT_W'(r_failed_at);
        end
    end

    trac_angle u_angle (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_start     (r_start),
        .i_x1        (r_prev_x[1]),
        .i_y1        (r_prev_y[1]),
        .i_x2        (r_prev_x[0]),
        .i_y2        (r_prev_y[0]),
        .i_x3        (r_in_x),
        .i_y3        (r_in_y),
        .i_cos_limit (r_cos_limit),
        .i_sin_limit (r_sin_limit),
        .i_min_dist  (r_min_dist),
        .o_sts       (w_sts)
    );

    assign o_valid      = r_out_valid;
    assign o_pass       = r_pass;
    assign o_fail_index = r_fail_index;

    `TRAC_ASSERT(a_done_in_calc, i_clk, i_rst_n, w_sts.done |-> (r_state == ST_CALC), "angle result outside calc")
    `TRAC_ASSERT(a_pass_zero_idx, i_clk, i_rst_n, (o_valid && o_pass) |-> (o_fail_index == '0), "pass with nonzero index")
    `TRAC_ASSERT(a_fail_idx_range, i_clk, i_rst_n, r_failed |-> (r_failed_at <= IDX_W'(MAX_POINTS - 3)), "fail index past end")

endmodule

// ===== tb/trac_result_monitor.sv =====
// Monitor for the relative-angle check: mirrors the track state, predicts and checks results
`timescale 1ns / 1ps

module trac_result_monitor (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_cfg_wr_en,
    input  logic [trac_pkg::CFG_ADDR_W-1:0]     i_cfg_addr,
    input  logic [trac_pkg::CFG_DATA_W-1:0]     i_cfg_wr_data,
    input  logic                                i_in_valid,
    input  logic                                i_in_ready,
    input  logic signed [trac_pkg::POS_W-1:0]   i_pos_x,
    input  logic signed [trac_pkg::POS_W-1:0]   i_pos_y,
    input  logic                                i_reversing,
    input  logic                                i_last,
    input  logic                                i_out_valid,
    input  logic                                i_out_ready,
    input  logic                                i_pass,
    input  logic [trac_pkg::IDX_OUT_W-1:0]      i_fail_index,
    output int                                  o_pending,
    output int                                  o_fail_count
);
    import trac_pkg::*;

    localparam int LAST_INDEX = DEF_MAX_POINTS - 1;

    typedef logic signed [127:0] t_wide;

    typedef struct packed {
        logic                 pass;
        logic [IDX_OUT_W-1:0] fail_index;
    } t_verdict;

    // Limit registers as last written
    logic signed [COS_W-1:0] cos_lim;
    logic [SIN_W-1:0]        sin_lim;
    logic [DIST_W-1:0]       min_dist;

    // Track state, entry 0 is the newest point
    logic signed [POS_W-1:0] prev_x [2];
    logic signed [POS_W-1:0] prev_y [2];
    logic                    prev_rev [2];
    logic [IDX_OUT_W-1:0]    point_idx;
    logic                    failed;
    logic [IDX_OUT_W-1:0]    failed_at;

    t_verdict verdict_q [$];
    int       errors = 0;

    function automatic void clear_track();
        prev_x[0]   = '0;
        prev_x[1]   = '0;
        prev_y[0]   = '0;
        prev_y[1]   = '0;
        prev_rev[0] = 1'b0;
        prev_rev[1] = 1'b0;
        point_idx   = '0;
        failed      = 1'b0;
        failed_at   = '0;
    endfunction

    always @(posedge i_clk) begin : watch
        longint   ax, ay, bx, by, md, dot, crs, c_abs;
        t_wide    lhs, rhs;
        logic     hit;
        t_verdict got, want;

        if (!i_rst_n) begin
            cos_lim  = COS_LIMIT_RST;
            sin_lim  = SIN_LIMIT_RST;
            min_dist = MIN_DIST_RST;
            clear_track();
            verdict_q.delete();
        end else begin
            // register writes
            if (i_cfg_wr_en) begin
                case (i_cfg_addr)
                    CFG_COS_LIMIT: cos_lim  = i_cfg_wr_data;
                    CFG_SIN_LIMIT: sin_lim  = i_cfg_wr_data[SIN_W-1:0];
                    CFG_MIN_DIST:  min_dist = i_cfg_wr_data;
                    default: ;
                endcase
            end

            // accepted point: check the window it closes, then shift or finish
            if (i_in_valid && i_in_ready) begin
                hit = 1'b0;
                if (point_idx >= 2 && !failed && !i_reversing && !prev_rev[0] && !prev_rev[1]) begin
                    ax = longint'(prev_x[0]) - longint'(prev_x[1]);
                    ay = longint'(prev_y[0]) - longint'(prev_y[1]);
                    bx = longint'(i_pos_x) - longint'(prev_x[1]);
                    by = longint'(i_pos_y) - longint'(prev_y[1]);
                    md = longint'(min_dist) * longint'(min_dist);
                    // short legs and zero vectors never fail
                    if (ax * ax + ay * ay >= md && bx * bx + by * by >= md &&
                        (ax != 0 || ay != 0) && (bx != 0 || by != 0)) begin
                        dot   = ax * bx + ay * by;
                        crs   = ax * by - ay * bx;
                        c_abs = (crs < 0) ? -crs : crs;
                        if (c_abs == 0 && dot < 0) begin
                            // straight back: only a threshold of pi lets it through
                            hit = !(sin_lim == '0 && cos_lim < 0);
                        end else begin
                            lhs = t_wide'(c_abs) * t_wide'(longint'(cos_lim));
                            rhs = t_wide'(dot) * t_wide'(longint'(sin_lim));
                            hit = lhs > rhs;
                        end
                    end
                    if (hit) begin
                        failed    = 1'b1;
                        failed_at = point_idx - IDX_OUT_W'(2);
                    end
                end
                if (i_last) begin
                    want.pass       = !failed;
                    want.fail_index = failed ? failed_at : '0;
                    verdict_q.push_back(want);
                    clear_track();
                end else begin
                    prev_x[1]   = prev_x[0];
                    prev_y[1]   = prev_y[0];
                    prev_rev[1] = prev_rev[0];
                    prev_x[0]   = i_pos_x;
                    prev_y[0]   = i_pos_y;
                    prev_rev[0] = i_reversing;
                    if (point_idx < LAST_INDEX) point_idx = point_idx + IDX_OUT_W'(1);
                end
            end

            // result word against the oldest prediction
            if (i_out_valid && i_out_ready) begin
                got.pass       = i_pass;
                got.fail_index = i_fail_index;
                if (verdict_q.size() == 0) begin
                    $display("%0t: unexpected result, got pass=%0b fail_index=%0d",
                             $time, got.pass, got.fail_index);
                    errors++;
                end else begin
                    want = verdict_q.pop_front();
                    if (got.pass !== want.pass) begin
                        $display("%0t: pass wrong, expected %0b, got %0b",
                                 $time, want.pass, got.pass);
                        errors++;
                    end
                    if (got.fail_index !== want.fail_index) begin
                        $display("%0t: fail_index wrong, expected %0d, got %0d",
                                 $time, want.fail_index, got.fail_index);
                        errors++;
                    end
                end
            end
        end
        o_pending    <= verdict_q.size();
        o_fail_count <= errors;
    end

endmodule

// ===== tb/tb.sv =====
// Testbench top for the relative-angle check: clock, reset, stimulus, receiver and verdict
`timescale 1ns / 1ps

module tb;
    import trac_pkg::*;

    typedef logic signed [POS_W-1:0] t_pos;

    localparam t_pos P_MAX       = {1'b0, {(POS_W-1){1'b1}}};
    localparam t_pos P_MIN       = {1'b1, {(POS_W-1){1'b0}}};
    localparam int   CYCLE_LIMIT = 1000000;
    localparam int   SETTLE      = 40;      // longer than one checked window
    localparam int   LONG_HOLD   = 400;
    localparam int   PHASES      = 8;
    localparam int   PHASE_ITEMS = 140;
    localparam longint STEP_SPAN = 64'sd134217728;

    logic                  i_clk = 1'b0;
    logic                  i_rst_n = 1'b0;
    logic                  i_cfg_wr_en = 1'b0;
    logic [CFG_ADDR_W-1:0] i_cfg_addr = '0;
    logic [CFG_DATA_W-1:0] i_cfg_wr_data = '0;
    logic                  i_valid = 1'b0;
    logic                  o_ready;
    t_pos                  i_pos_x = '0;
    t_pos                  i_pos_y = '0;
    logic                  i_reversing = 1'b0;
    logic                  i_last = 1'b0;
    logic                  o_valid;
    logic                  i_ready = 1'b0;
    logic                  o_pass;
    logic [IDX_OUT_W-1:0]  o_fail_index;

    int pending;
    int fail_count;
    int cyc = 0;
    int hold_requests = 0;
    int holds_done = 0;
    int hold_left = 0;
    int burst_left = 0;
    int items_sent = 0;
    int cur_min_dist = MIN_DIST_RST;

    always #6 i_clk = ~i_clk;

    trajectory_relative_angle_check_unit dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_wr_en   (i_cfg_wr_en),
        .i_cfg_addr    (i_cfg_addr),
        .i_cfg_wr_data (i_cfg_wr_data),
        .i_valid       (i_valid),
        .o_ready       (o_ready),
        .i_pos_x       (i_pos_x),
        .i_pos_y       (i_pos_y),
        .i_reversing   (i_reversing),
        .i_last        (i_last),
        .o_valid       (o_valid),
        .i_ready       (i_ready),
        .o_pass        (o_pass),
        .o_fail_index  (o_fail_index)
    );

    trac_result_monitor u_monitor (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_wr_en   (i_cfg_wr_en),
        .i_cfg_addr    (i_cfg_addr),
        .i_cfg_wr_data (i_cfg_wr_data),
        .i_in_valid    (i_valid),
        .i_in_ready    (o_ready),
        .i_pos_x       (i_pos_x),
        .i_pos_y       (i_pos_y),
        .i_reversing   (i_reversing),
        .i_last        (i_last),
        .i_out_valid   (o_valid),
        .i_out_ready   (i_ready),
        .i_pass        (o_pass),
        .i_fail_index  (o_fail_index),
        .o_pending     (pending),
        .o_fail_count  (fail_count)
    );

    // Cycle count and run limit
    always @(posedge i_clk) begin
        cyc <= cyc + 1;
        if (cyc >= CYCLE_LIMIT) begin
            $display("simulation failed");
            $finish;
        end
    end

    // Result side: long hold on request, otherwise a stall pattern picked by cycle count bits 9:7
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_ready <= 1'b0;
        end else if (hold_left != 0) begin
            i_ready   <= 1'b0;
            hold_left <= hold_left - 1;
        end else if (holds_done != hold_requests) begin
            i_ready    <= 1'b0;
            holds_done <= holds_done + 1;
            hold_left  <= LONG_HOLD;
        end else begin
            case (cyc[9:7])
                3'd2:    i_ready <= 1'($urandom_range(0, 1));
                3'd3:    i_ready <= (cyc[1:0] == 2'd0);
                3'd4:    i_ready <= ($urandom_range(0, 7) == 0);
                3'd5:    i_ready <= cyc[0];
                3'd6,
                3'd7:    i_ready <= ($urandom_range(0, 3) != 0);
                default: i_ready <= 1'b1;
            endcase
        end
    end

    // Uniform in [-s, s]
    function automatic longint spread(input longint s);
        return longint'($urandom_range(0, 2 * s)) - s;
    endfunction

    // One point word; the sender runs in bursts with random gaps between them
    task automatic send_point(input t_pos x, input t_pos y, input logic rev, input logic fin);
        int gap;
        bit rdy;
        if (burst_left == 0) begin
            gap        = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
            burst_left = $urandom_range(1, 24);
            if (gap > 0) begin
                i_valid <= 1'b0;
                repeat (gap) @(posedge i_clk);
            end
        end
        burst_left--;
        i_valid     <= 1'b1;
        i_pos_x     <= x;
        i_pos_y     <= y;
        i_reversing <= rev;
        i_last      <= fin;
        do begin
            @(negedge i_clk);
            rdy = o_ready;
            @(posedge i_clk);
        end while (!rdy);
        items_sent++;
    endtask

    // Stop sending, wait for every result, then let a window in flight finish
    task automatic drain();
        i_valid    <= 1'b0;
        burst_left = 0;
        do @(posedge i_clk); while (pending != 0);
        repeat (SETTLE) @(posedge i_clk);
    endtask

    // Write all three limit registers while the block is idle
    task automatic write_limits(input logic [15:0] cos_word, input logic [15:0] sin_word,
                                input logic [15:0] dist_word);
        drain();
        i_cfg_wr_en   <= 1'b1;
        i_cfg_addr    <= CFG_COS_LIMIT;
        i_cfg_wr_data <= cos_word;
        @(posedge i_clk);
        i_cfg_addr    <= CFG_SIN_LIMIT;
        i_cfg_wr_data <= sin_word;
        @(posedge i_clk);
        i_cfg_addr    <= CFG_MIN_DIST;
        i_cfg_wr_data <= dist_word;
        @(posedge i_clk);
        i_cfg_wr_en   <= 1'b0;
        cur_min_dist  = dist_word;
    endtask

    initial begin : stimulus
        int     ph, k, npts, target;
        longint px, py, sx, sy, scale;
        bit     smooth;

        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed: short tracks, a right turn, extremes, straight back,
        // reversing point, short leg, failure in the second window
        send_point(0, 0, 1'b0, 1'b1);
        send_point(5, 5, 1'b0, 1'b0);
        send_point(7, 9, 1'b0, 1'b1);
        send_point(0, 0, 1'b0, 1'b0);
        send_point(1000, 0, 1'b0, 1'b0);
        send_point(0, 1000, 1'b0, 1'b1);
        send_point(P_MIN, P_MIN, 1'b0, 1'b0);
        send_point(P_MAX, P_MAX, 1'b0, 1'b0);
        send_point(P_MAX, P_MIN, 1'b0, 1'b1);
        send_point(0, 0, 1'b0, 1'b0);
        send_point(5000, 0, 1'b0, 1'b0);
        send_point(-5000, 0, 1'b0, 1'b1);
        send_point(0, 0, 1'b0, 1'b0);
        send_point(1000, 0, 1'b1, 1'b0);
        send_point(0, 1000, 1'b0, 1'b1);
        send_point(0, 0, 1'b0, 1'b0);
        send_point(10, 0, 1'b0, 1'b0);
        send_point(0, 1000, 1'b0, 1'b1);
        send_point(0, 0, 1'b0, 1'b0);
        send_point(1000, 0, 1'b0, 1'b0);
        send_point(2000, 0, 1'b0, 1'b0);
        send_point(2000, 3000, 1'b0, 1'b1);

        for (ph = 0; ph < PHASES; ph++) begin
            case (ph)
                1: write_limits(16'h7FFF, 16'h0000, 16'd0);
                2: write_limits(16'h8000, 16'h0000, 16'hFFFF);
                3: write_limits(16'h0000, 16'hFFFF, 16'd51);
                4: write_limits(-16'sd23170, 16'd23170, 16'd1000);
                5: write_limits(16'h0000, 16'h0000, 16'd200);
                6: write_limits(16'($urandom), 16'($urandom), 16'($urandom_range(0, 3000)));
                7: write_limits(16'sd23170, 16'd23170, 16'd51);
                default: ;
            endcase

            // zero vectors with no minimum distance
            if (ph == 1) begin
                send_point(0, 0, 1'b0, 1'b0);
                send_point(0, 0, 1'b0, 1'b0);
                send_point(5, 5, 1'b0, 1'b1);
                send_point(3, 3, 1'b0, 1'b0);
                send_point(9, 9, 1'b0, 1'b0);
                send_point(3, 3, 1'b0, 1'b1);
            end

            // receiver holds off while single-point tracks pile up
            if (ph == 2 || ph == 5) begin
                hold_requests <= hold_requests + 1;
                repeat (40) send_point(t_pos'($urandom), t_pos'($urandom),
                                       1'($urandom_range(0, 1)), 1'b1);
            end

            // Random tracks: mostly smooth walks, some wild turns and noise points
            target = items_sent + PHASE_ITEMS;
            while (items_sent < target) begin
                case ($urandom_range(0, 9))
                    0, 1:    npts = $urandom_range(1, 3);
                    2:       npts = $urandom_range(13, 40);
                    default: npts = $urandom_range(4, 12);
                endcase
                case ($urandom_range(0, 5))
                    0:       scale = $urandom_range(1, 64);
                    1:       scale = cur_min_dist + $urandom_range(0, 64);
                    2:       scale = $urandom_range(100, 5000);
                    3:       scale = $urandom_range(5000, 2000000);
                    default: scale = longint'(1) << $urandom_range(20, 26);
                endcase
                smooth = ($urandom_range(0, 4) != 0);
                px = spread(STEP_SPAN);
                py = spread(STEP_SPAN);
                sx = spread(scale);
                sy = spread(scale);
                for (k = 0; k < npts; k++) begin
                    if ($urandom_range(0, 15) == 0)
                        send_point(t_pos'($urandom), t_pos'($urandom),
                                   $urandom_range(0, 19) == 0, k == npts - 1);
                    else
                        send_point(px[POS_W-1:0], py[POS_W-1:0], $urandom_range(0, 19) == 0,
                                   k == npts - 1);
                    px += sx;
                    py += sy;
                    if (!smooth) begin
                        sx = spread(scale);
                        sy = spread(scale);
                    end else begin
                        case ($urandom_range(0, 9))
                            0: begin
                                // doubles back past the previous point
                                sx = -2 * sx;
                                sy = -2 * sy;
                            end
                            1: begin
                                sx = spread(scale);
                                sy = spread(scale);
                            end
                            default: begin
                                sx += spread(scale / 4);
                                sy += spread(scale / 4);
                            end
                        endcase
                    end
                    if (sx > STEP_SPAN || sx < -STEP_SPAN) sx = spread(scale);
                    if (sy > STEP_SPAN || sy < -STEP_SPAN) sy = spread(scale);
                end
            end
        end

        drain();
        if (fail_count == 0)
            $display("simulation ok");
        else
            $display("simulation failed");
        $finish;
    end

endmodule

// ===== files.f =====
+incdir+hw/rtl
hw/rtl/trac_pkg.sv
hw/rtl/trac_mul.sv
hw/rtl/trac_angle.sv
hw/rtl/trajectory_relative_angle_check_unit.sv
tb/trac_result_monitor.sv
tb/tb.sv
